>>> rtl/core/ppc_pkg.sv
// Shared types and constants of the point-to-plane classifier.
package ppc_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DIST_W    = 31;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int DM_W      = WORD_W + FRAC_BITS;
    // quotient bits produced by each divider; offsets clamp at 2^(QSTEPS-1)
    localparam int QSTEPS    = 34;
    localparam int NUM_W     = PROD_W + WORD_W;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_DOT    = 3'd6;

    localparam logic [WORD_W-1:0] PLANE_C_RESET = WORD_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic signed [WORD_W-1:0] point_x;
        logic signed [WORD_W-1:0] point_y;
        logic signed [WORD_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic                     is_inlier;
        logic signed [WORD_W-1:0] closest_x;
        logic signed [WORD_W-1:0] closest_y;
        logic signed [WORD_W-1:0] closest_z;
        logic        [DIST_W-1:0] plane_distance;
        logic signed [WORD_W-1:0] side_distance;
        logic                     degenerate;
    } t_result;

    function automatic logic [WORD_W-1:0] mag32(logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? WORD_W'(~v + 1'b1) : v;
    endfunction

endpackage

>>> rtl/core/point_plane_classifier_core.sv
// Point-to-plane projection, distance and inlier classification pipeline.
// Pipeline of 40 register stages; it accepts one item per cycle unless the
// output stalls or the |n| recompute below is running.
// Writing plane_a, plane_b or plane_c starts a recompute of |n|^2
// and its square root (square and sum the components, then 32 root steps);
// input ready stays low until it ends.
// Reset (synchronous, active low) empties the pipeline, loads the register
// reset values and their precomputed |n|^2 = 1.0 and |n| = 1.0.
module point_plane_classifier_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ppc_pkg::t_point              i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ppc_pkg::t_result             o_out_item,
    input  logic                         i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ppc_pkg::WORD_W-1:0]   i_cfg_data
);
    import ppc_pkg::*;

    localparam int NST = QSTEPS + 6;
    localparam int DV0 = 4;

    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_SQ   = 2'd1;
    localparam logic [1:0] SEQ_ROOT = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [QSTEPS-1:0] QCLAMP   = QSTEPS'(1) << (QSTEPS - 1);

    typedef struct packed {
        logic [2:0][PROD_W-1:0] prod;
        logic [2:0]             negf;
        logic [DM_W-1:0]        dm;
        logic                   dneg;
        logic [2:0][WORD_W-1:0] p;
    } t_sa;

    typedef struct packed {
        logic [PROD_W-1:0]      pos;
        logic [PROD_W-1:0]      neg;
        logic [2:0][WORD_W-1:0] p;
    } t_sb;

    typedef struct packed {
        logic [PROD_W-1:0]      vmag;
        logic                   vpos;
        logic                   vneg;
        logic [2:0][WORD_W-1:0] p;
    } t_sc;

    typedef struct packed {
        logic [2:0][PROD_W-1:0] pl;
        logic [2:0][PROD_W-1:0] ph;
        logic [PROD_W-1:0]      vmag;
        logic                   vpos;
        logic                   vneg;
        logic [2:0][WORD_W-1:0] p;
    } t_sd;

    typedef struct packed {
        logic [2:0][PROD_W-1:0] rem_o;
        logic [2:0][QSTEPS-1:0] w_o;
        logic [2:0]             sat_o;
        logic [WORD_W-1:0]      rem_d;
        logic [QSTEPS-1:0]      w_d;
        logic                   sat_d;
        logic                   vpos;
        logic                   vneg;
        logic [2:0][WORD_W-1:0] p;
    } t_div;

    function automatic t_div div_step(t_div x, logic [PROD_W-1:0] n2, logic [WORD_W-1:0] s);
        t_div              y;
        logic [PROD_W:0]   t;
        logic [WORD_W:0]   td;
        logic              ge;
        y = x;
        for (int i = 0; i < 3; i++) begin
            t  = {x.rem_o[i], x.w_o[i][QSTEPS-1]};
            ge = t >= {1'b0, n2};
            y.rem_o[i] = ge ? PROD_W'(t - {1'b0, n2}) : t[PROD_W-1:0];
            y.w_o[i]   = {x.w_o[i][QSTEPS-2:0], ge};
        end
        td = {x.rem_d, x.w_d[QSTEPS-1]};
        ge = td >= {1'b0, s};
        y.rem_d = ge ? WORD_W'(td - {1'b0, s}) : td[WORD_W-1:0];
        y.w_d   = {x.w_d[QSTEPS-2:0], ge};
        return y;
    endfunction

    // configuration registers
    logic [WORD_W-1:0] r_a, r_b, r_c, r_d, r_u;
    logic [DIST_W-1:0] r_thr;
    logic              r_fid;

    // |n|^2 and floor(sqrt) sequencer
    logic [1:0]        r_seq;
    logic [4:0]        r_cnt;
    logic [PROD_W-1:0] r_sq, r_n2, r_rem, r_res, r_bit;
    logic [WORD_W-1:0] r_s;
    logic [WORD_W-1:0] m_sel;
    logic [PROD_W-1:0] n_sq, n_t, n_rem, n_res;
    logic              busy;

    logic [2:0][WORD_W-1:0] m_n;
    assign m_n[0] = mag32(r_a);
    assign m_n[1] = mag32(r_b);
    assign m_n[2] = mag32(r_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a   <= '0;
            r_b   <= '0;
            r_c   <= PLANE_C_RESET;
            r_d   <= '0;
            r_thr <= '0;
            r_fid <= 1'b1;
            r_u   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PLANE_A:   r_a   <= i_cfg_data;
                CFG_PLANE_B:   r_b   <= i_cfg_data;
                CFG_PLANE_C:   r_c   <= i_cfg_data;
                CFG_PLANE_D:   r_d   <= i_cfg_data;
                CFG_THRESHOLD: r_thr <= i_cfg_data[DIST_W-1:0];
                CFG_FRAME_ID:  r_fid <= i_cfg_data[0];
                CFG_UP_DOT:    r_u   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    m_sel = m_n[0];
            2'd1:    m_sel = m_n[1];
            2'd2:    m_sel = m_n[2];
            default: m_sel = '0;
        endcase
        n_sq  = m_sel * m_sel;
        n_t   = r_res + r_bit;
        n_rem = r_rem;
        n_res = r_res >> 1;
        if (r_rem >= n_t) begin
            n_rem = r_rem - n_t;
            n_res = (r_res >> 1) + r_bit;
        end
    end

    assign busy = r_seq != SEQ_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SEQ_IDLE;
            r_cnt <= '0;
            r_n2  <= PROD_W'(1) << (2 * FRAC_BITS);
            r_s   <= WORD_W'(1) << FRAC_BITS;
        end else if (i_cfg_we && (i_cfg_idx == CFG_PLANE_A || i_cfg_idx == CFG_PLANE_B ||
                                  i_cfg_idx == CFG_PLANE_C)) begin
            // restart on every write of plane_a, plane_b or plane_c
            r_seq <= SEQ_SQ;
            r_cnt <= '0;
            r_n2  <= '0;
        end else begin
            unique case (r_seq)
                SEQ_SQ: begin
                    r_sq <= n_sq;
                    if (r_cnt != 5'd0) r_n2 <= r_n2 + r_sq;
                    if (r_cnt == 5'd3) begin
                        r_seq <= SEQ_ROOT;
                        r_cnt <= '0;
                        r_rem <= r_n2 + r_sq;
                        r_res <= '0;
                        r_bit <= PROD_W'(1) << (PROD_W - 2);
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                SEQ_ROOT: begin
                    r_rem <= n_rem;
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_seq <= SEQ_IDLE;
                        r_s   <= n_res[WORD_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // pipeline flow: a stage loads when it is empty or its item moves on
    logic [NST-1:0] r_v;
    logic [NST:0]   en;
    logic           acc;

    always_comb begin
        en[NST] = i_out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_in_ready  = en[0] && !busy;
    assign acc         = i_in_valid && o_in_ready;
    assign o_out_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (en[NST-1:0] & {r_v[NST-2:0], acc}) | (~en[NST-1:0] & r_v);
        end
    end

    // stage A: per-axis products
    t_sa r_sa, n_sa;
    logic [2:0][WORD_W-1:0] p_in;
    assign p_in[0] = i_in_item.point_x;
    assign p_in[1] = i_in_item.point_y;
    assign p_in[2] = i_in_item.point_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sa.prod[i] = m_n[i] * mag32(p_in[i]);
            n_sa.negf[i] = (i == 0 ? r_a[WORD_W-1] : i == 1 ? r_b[WORD_W-1] : r_c[WORD_W-1])
                           != p_in[i][WORD_W-1];
        end
        n_sa.dm   = DM_W'(mag32(r_d)) << FRAC_BITS;
        n_sa.dneg = r_d[WORD_W-1];
        n_sa.p    = p_in;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) r_sa <= n_sa;
    end

    // stage B: split sums by sign
    t_sb r_sb, n_sb;
    always_comb begin
        n_sb.pos = r_sa.dneg ? '0 : PROD_W'(r_sa.dm);
        n_sb.neg = r_sa.dneg ? PROD_W'(r_sa.dm) : '0;
        for (int i = 0; i < 3; i++) begin
            if (r_sa.negf[i]) n_sb.neg = n_sb.neg + r_sa.prod[i];
            else              n_sb.pos = n_sb.pos + r_sa.prod[i];
        end
        n_sb.p = r_sa.p;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) r_sb <= n_sb;
    end

    // stage C: plane value as sign and magnitude
    t_sc r_sc, n_sc;
    always_comb begin
        n_sc.vpos = r_sb.pos > r_sb.neg;
        n_sc.vneg = r_sb.neg > r_sb.pos;
        n_sc.vmag = n_sc.vpos ? r_sb.pos - r_sb.neg : r_sb.neg - r_sb.pos;
        n_sc.p    = r_sb.p;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) r_sc <= n_sc;
    end

    // stage D: |v| * |n_i| as two 32x32 partial products
    t_sd r_sd, n_sd;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sd.pl[i] = r_sc.vmag[WORD_W-1:0] * m_n[i];
            n_sd.ph[i] = r_sc.vmag[PROD_W-1:WORD_W] * m_n[i];
        end
        n_sd.vmag = r_sc.vmag;
        n_sd.vpos = r_sc.vpos;
        n_sd.vneg = r_sc.vneg;
        n_sd.p    = r_sc.p;
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) r_sd <= n_sd;
    end

    // stage E: divider setup and overflow detect; then one quotient bit a stage
    t_div r_dv [0:QSTEPS];
    t_div n_dv0;
    logic [NUM_W-1:0] num;

    always_comb begin
        num = '0;
        for (int i = 0; i < 3; i++) begin
            num = NUM_W'(r_sd.pl[i]) + {r_sd.ph[i], {WORD_W{1'b0}}};
            n_dv0.sat_o[i] = PROD_W'(num[NUM_W-1:QSTEPS]) >= r_n2;
            n_dv0.rem_o[i] = PROD_W'(num[NUM_W-1:QSTEPS]);
            n_dv0.w_o[i]   = num[QSTEPS-1:0];
        end
        n_dv0.sat_d = WORD_W'(r_sd.vmag[PROD_W-1:QSTEPS]) >= r_s;
        n_dv0.rem_d = WORD_W'(r_sd.vmag[PROD_W-1:QSTEPS]);
        n_dv0.w_d   = r_sd.vmag[QSTEPS-1:0];
        n_dv0.vpos  = r_sd.vpos;
        n_dv0.vneg  = r_sd.vneg;
        n_dv0.p     = r_sd.p;
    end

    always_ff @(posedge i_clk) begin
        if (en[DV0]) r_dv[0] <= n_dv0;
        for (int k = 1; k <= QSTEPS; k++) begin
            if (en[DV0+k]) r_dv[k] <= div_step(r_dv[k-1], r_n2, r_s);
        end
    end

    // output stage: clamp, project, classify
    t_result r_out, n_out;
    t_div    fin;
    logic [DIST_W-1:0]      dist_sat;
    logic [2:0][WORD_W-1:0] cl;
    logic [QSTEPS-1:0]      qm;
    logic [QSTEPS+1:0]      pe, diff;
    logic                   offneg, upos, inl;

    assign fin = r_dv[QSTEPS];

    always_comb begin
        dist_sat = (fin.sat_d || fin.w_d > QSTEPS'(DIST_MAX)) ? DIST_MAX
                                                               : fin.w_d[DIST_W-1:0];
        for (int i = 0; i < 3; i++) begin
            qm = (fin.sat_o[i] || fin.w_o[i] > QCLAMP) ? QCLAMP : fin.w_o[i];
            offneg = fin.vneg != m_n[i][0] ^ m_n[i][0]
                     ^ (i == 0 ? r_a[WORD_W-1] : i == 1 ? r_b[WORD_W-1] : r_c[WORD_W-1]);
            pe   = {{(QSTEPS + 2 - WORD_W){fin.p[i][WORD_W-1]}}, fin.p[i]};
            // closest = p - offset, offset negated when the signs differ
            diff = offneg ? pe + {2'b00, qm} : pe - {2'b00, qm};
            if (!diff[QSTEPS+1] && diff[QSTEPS:WORD_W-1] != '0) begin
                cl[i] = {1'b0, {(WORD_W-1){1'b1}}};
            end else if (diff[QSTEPS+1] && diff[QSTEPS:WORD_W-1] != '1) begin
                cl[i] = {1'b1, {(WORD_W-1){1'b0}}};
            end else begin
                cl[i] = diff[WORD_W-1:0];
            end
        end
        upos = !r_u[WORD_W-1] && r_u != '0;
        priority if (dist_sat < r_thr) inl = 1'b1;
        else if (r_fid)                inl = 1'b0;
        else                           inl = (fin.vpos && r_u[WORD_W-1]) || (fin.vneg && upos);

        if (r_n2 == '0) begin
            n_out.is_inlier      = 1'b0;
            n_out.closest_x      = fin.p[0];
            n_out.closest_y      = fin.p[1];
            n_out.closest_z      = fin.p[2];
            n_out.plane_distance = '0;
            n_out.side_distance  = '0;
            n_out.degenerate     = 1'b1;
        end else begin
            n_out.is_inlier      = inl;
            n_out.closest_x      = cl[0];
            n_out.closest_y      = cl[1];
            n_out.closest_z      = cl[2];
            n_out.plane_distance = dist_sat;
            n_out.side_distance  = fin.vpos ? {1'b0, dist_sat}
                                            : WORD_W'(0) - {1'b0, dist_sat};
            n_out.degenerate     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) r_out <= n_out;
    end

    assign o_out_item = r_out;

endmodule

>>> test/tb.sv
// Self-checking testbench for the point-to-plane classifier core.
module tb;
    import ppc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic signed [WORD_W-1:0] S_MAX = 32'sh7fffffff;
    localparam logic signed [WORD_W-1:0] S_MIN = 32'sh80000000;
    localparam logic signed [WORD_W-1:0] ONE   = 32'sd65536;

    typedef struct {
        int unsigned setup;
        t_point      pt;
        bit          typed;
        t_result     want;
    } t_row;

    logic    i_clk = 0;
    logic    i_rst_n = 0;
    logic    i_in_valid = 0;
    logic    o_in_ready;
    t_point  i_in_item = '0;
    logic    o_out_valid;
    logic    i_out_ready = 0;
    t_result o_out_item;
    logic    i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    // shadow copy of the block's registers
    logic signed [WORD_W-1:0] sh_a = 0, sh_b = 0, sh_c = ONE, sh_d = 0, sh_up = 0;
    logic [DIST_W-1:0]        sh_thr = 0;
    logic                     sh_frame = 1;

    t_result pending_q[$];
    t_row    rows[$];
    int      n_mism = 0;
    int      n_items = 0;
    int      n_results = 0;
    int      n_inlier = 0;
    int      n_degen = 0;
    bit      no_idle = 0;
    int      gap_pct = 15;
    int      stall_left = 0;

    point_plane_classifier_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // project the point on the configured plane and classify it
    function automatic t_result project_point(t_point pt);
        logic signed [63:0] n[3];
        logic signed [63:0] p[3];
        logic signed [63:0] off, cv;
        logic [63:0] n2, pos, neg, t, vmag, dist_v, rem, root, bt;
        logic [127:0] q;
        logic [63:0] qm;
        bit vpos, vneg, inl;
        t_result r;
        n[0] = sh_a; n[1] = sh_b; n[2] = sh_c;
        p[0] = pt.point_x; p[1] = pt.point_y; p[2] = pt.point_z;
        n2 = 0; pos = 0; neg = 0;
        for (int i = 0; i < 3; i++) begin
            n2 += abs64(n[i]) * abs64(n[i]);
            t = abs64(n[i]) * abs64(p[i]);
            if ((n[i] < 0) != (p[i] < 0)) neg += t; else pos += t;
        end
        t = abs64(64'(sh_d)) << FRAC_BITS;
        if (sh_d < 0) neg += t; else pos += t;
        r = '0;
        if (n2 == 0) begin
            r.closest_x = pt.point_x;
            r.closest_y = pt.point_y;
            r.closest_z = pt.point_z;
            r.degenerate = 1'b1;
            return r;
        end
        vpos = pos > neg;
        vneg = neg > pos;
        vmag = vpos ? pos - neg : neg - pos;
        // integer square root of |n|^2
        rem = n2; root = 0; bt = 64'd1 << 62;
        while (bt > rem) bt >>= 2;
        while (bt != 0) begin
            if (rem >= root + bt) begin
                rem -= root + bt;
                root = (root >> 1) + bt;
            end else begin
                root >>= 1;
            end
            bt >>= 2;
        end
        dist_v = vmag / root;
        if (dist_v > 64'h7fffffff) dist_v = 64'h7fffffff;
        for (int i = 0; i < 3; i++) begin
            q = (128'(vmag) * 128'(abs64(n[i]))) / 128'(n2);
            qm = (q > 128'(64'd1 << 33)) ? 64'd1 << 33 : q[63:0];
            off = $signed(qm);
            if (vneg != (n[i] < 0)) off = -off;
            cv = p[i] - off;
            if (cv > 64'sh7fffffff) cv = 64'sh7fffffff;
            if (cv < -64'sh80000000) cv = -64'sh80000000;
            if (i == 0) r.closest_x = cv[31:0];
            else if (i == 1) r.closest_y = cv[31:0];
            else r.closest_z = cv[31:0];
        end
        if (dist_v < 64'(sh_thr)) inl = 1;
        else if (sh_frame) inl = 0;
        else inl = (vpos && sh_up < 0) || (vneg && sh_up > 0);
        r.is_inlier = inl;
        r.plane_distance = dist_v[DIST_W-1:0];
        r.side_distance = vpos ? dist_v[31:0] : -dist_v[31:0];
        return r;
    endfunction

    // output side: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 0;
        end else if (!no_idle && $urandom_range(0, 99) < 10) begin
            stall_left <= $urandom_range(1, 12) - 1;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= 1;
        end
    end

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (pending_q.size() == 0) begin
                n_mism++;
                if (n_mism <= 10) $display("ERROR: unexpected result %h", o_out_item);
            end else begin
                w = pending_q.pop_front();
                if (o_out_item.is_inlier) n_inlier++;
                if (o_out_item.degenerate) n_degen++;
                if (o_out_item.is_inlier !== w.is_inlier ||
                    o_out_item.closest_x !== w.closest_x ||
                    o_out_item.closest_y !== w.closest_y ||
                    o_out_item.closest_z !== w.closest_z ||
                    o_out_item.plane_distance !== w.plane_distance ||
                    o_out_item.side_distance !== w.side_distance ||
                    o_out_item.degenerate !== w.degenerate) begin
                    n_mism++;
                    if (n_mism <= 10) begin
                        $display("ERROR: result %0d mismatch", n_results);
                        $display("  want inl=%b cl=%h %h %h dist=%h sd=%h deg=%b",
                                 w.is_inlier, w.closest_x, w.closest_y, w.closest_z,
                                 w.plane_distance, w.side_distance, w.degenerate);
                        $display("  got  inl=%b cl=%h %h %h dist=%h sd=%h deg=%b",
                                 o_out_item.is_inlier, o_out_item.closest_x,
                                 o_out_item.closest_y, o_out_item.closest_z,
                                 o_out_item.plane_distance, o_out_item.side_distance,
                                 o_out_item.degenerate);
                    end
                end
            end
        end
    end

    // hold valid until the item is taken, then maybe idle
    task automatic send_point(t_point pt, bit typed, t_result want);
        i_in_valid <= 1;
        i_in_item <= pt;
        do @(posedge i_clk); while (!o_in_ready);
        pending_q.insert(pending_q.size(), typed ? want : project_point(pt));
        n_items++;
        if (!no_idle && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    // caller lowers the write enable after the last write
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_PLANE_A:   sh_a = val;
            CFG_PLANE_B:   sh_b = val;
            CFG_PLANE_C:   sh_c = val;
            CFG_PLANE_D:   sh_d = val;
            CFG_THRESHOLD: sh_thr = val[DIST_W-1:0];
            CFG_FRAME_ID:  sh_frame = val[0];
            CFG_UP_DOT:    sh_up = val;
            default: ;
        endcase
    endtask

    task automatic cfg_plane(logic signed [31:0] a, logic signed [31:0] b,
                             logic signed [31:0] c, logic signed [31:0] d,
                             logic [31:0] thr, logic fr, logic signed [31:0] up);
        drain();
        cfg_write(CFG_PLANE_A, a);
        cfg_write(CFG_PLANE_B, b);
        cfg_write(CFG_PLANE_C, c);
        cfg_write(CFG_PLANE_D, d);
        cfg_write(CFG_THRESHOLD, thr);
        cfg_write(CFG_FRAME_ID, {31'b0, fr});
        cfg_write(CFG_UP_DOT, up);
        cfg_write(CFG_UNUSED, $urandom());
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_word(int mode);
        case ($urandom_range(0, 7))
            0: return S_MAX;
            1: return S_MIN;
            2: return 0;
            3, 4: return $urandom();
            default: return 32'($signed($urandom_range(0, 2 * mode)) - mode);
        endcase
    endfunction

    function automatic t_point rand_point();
        t_point pt;
        if ($urandom_range(0, 9) < 6) begin
            pt.point_x = $signed($urandom_range(0, 32'h100000)) - 32'sh80000;
            pt.point_y = $signed($urandom_range(0, 32'h100000)) - 32'sh80000;
            pt.point_z = $signed($urandom_range(0, 32'h100000)) - 32'sh80000;
        end else begin
            pt.point_x = rand_word(32'h7fffffff);
            pt.point_y = rand_word(32'h7fffffff);
            pt.point_z = rand_word(32'h7fffffff);
        end
        return pt;
    endfunction

    task automatic add_row(int unsigned setup, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, bit typed, t_result want);
        t_row r;
        r.setup = setup;
        r.pt.point_x = x; r.pt.point_y = y; r.pt.point_z = z;
        r.typed = typed;
        r.want = want;
        rows.insert(rows.size(), r);
    endtask

    function automatic t_result mk(logic inl, logic signed [31:0] cx, logic signed [31:0] cy,
                                   logic signed [31:0] cz, logic [30:0] pdist,
                                   logic signed [31:0] sd, logic deg);
        t_result r;
        r.is_inlier = inl; r.closest_x = cx; r.closest_y = cy; r.closest_z = cz;
        r.plane_distance = pdist; r.side_distance = sd; r.degenerate = deg;
        return r;
    endfunction

    initial begin
        t_result none;
        int unsigned cur;
        none = '0;
        // reset plane z = 0: on plane, then above it
        add_row(0, 0, 0, 0, 1, mk(0, 0, 0, 0, 0, 0, 0));
        add_row(0, ONE, 2 * ONE, 3 * ONE, 1,
                mk(0, ONE, 2 * ONE, 0, 31'd196608, 32'sd196608, 0));
        add_row(0, S_MAX, S_MAX, S_MAX, 0, none);
        add_row(0, S_MIN, S_MIN, S_MIN, 0, none);
        add_row(0, S_MAX, S_MIN, -1, 0, none);
        // zero normal
        add_row(1, S_MAX, S_MIN, 5, 1, mk(0, S_MAX, S_MIN, 5, 0, 0, 1));
        add_row(1, S_MIN, 0, S_MAX, 1, mk(0, S_MIN, 0, S_MAX, 0, 0, 1));
        add_row(1, -7, 123, 0, 1, mk(0, -7, 123, 0, 0, 0, 1));
        // extreme plane, saturating outputs
        add_row(2, S_MAX, S_MAX, S_MAX, 0, none);
        add_row(2, S_MIN, S_MIN, S_MIN, 0, none);
        add_row(2, S_MIN, S_MAX, S_MIN, 0, none);
        add_row(2, S_MAX, S_MIN, S_MAX, 0, none);
        add_row(2, 0, 0, 0, 0, none);
        add_row(2, 1, -1, 1, 0, none);
        // plane x = 0, side test against positive up_dot
        add_row(3, -2 * ONE, 0, 0, 1, mk(1, 0, 0, 0, 31'd131072, -32'sd131072, 0));
        add_row(3, 0, 5 * ONE, -ONE, 1, mk(0, 0, 5 * ONE, -ONE, 0, 0, 0));
        add_row(3, 3 * ONE, ONE, ONE, 0, none);
        add_row(3, S_MAX, 0, 0, 0, none);
        add_row(3, S_MIN, 0, 0, 0, none);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        cur = 0;
        foreach (rows[i]) begin
            if (rows[i].setup != cur) begin
                cur = rows[i].setup;
                case (cur)
                    1: cfg_plane(0, 0, 0, S_MAX, 32'h7fffffff, 0, S_MIN);
                    2: cfg_plane(S_MIN, S_MAX, S_MIN, S_MIN, 32'h7fffffff, 0, S_MIN);
                    default: cfg_plane(ONE, 0, 0, 0, 0, 0, S_MAX);
                endcase
            end
            send_point(rows[i].pt, rows[i].typed, rows[i].want);
        end

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) cfg_plane(0, 0, ONE, -ONE, 32'h7fffffff, 1, 0);
            else if (ph == 6) cfg_plane(S_MIN, S_MIN, S_MIN, S_MAX, 0, 1, S_MAX);
            else
                cfg_plane(rand_word(4 * ONE), rand_word(4 * ONE), rand_word(4 * ONE),
                          rand_word(16 * ONE),
                          ($urandom_range(0, 3) == 0) ? $urandom() & 32'h7fffffff
                                                      : $urandom_range(0, 8 * ONE),
                          $urandom_range(0, 1), rand_word(2 * ONE));
            gap_pct = (ph % 3 == 2) ? 0 : $urandom_range(5, 40);
            if (ph == 7) no_idle = 1;
            for (int k = 0; k < 215; k++) begin
                if (ph == 0 && k == 100) drain();
                send_point(rand_point(), 0, none);
            end
        end

        drain();
        $display("Sent %0d points over directed and 8 random plane settings;", n_items);
        $display("checked %0d results: %0d inliers, %0d degenerate.",
                 n_results, n_inlier, n_degen);
        if (n_mism == 0 && pending_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
